// ===== design/per_source_connection_admission_assert.svh =====
// assertion macros for the per-source connection admission block
`ifndef PER_SOURCE_CONNECTION_ADMISSION_ASSERT_SVH
`define PER_SOURCE_CONNECTION_ADMISSION_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked on every clock edge outside reset
`define PSCA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psca: same-cycle check failed");

// next-cycle implication
`define PSCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psca: next-cycle check failed");

`else

`define PSCA_ASSERT_IMPLY(label, ante, cons)
`define PSCA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/psca_pkg.sv =====
// types and constants for the per-source connection admission block
package psca_pkg;

	localparam int KEY_W     = 64;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPEN = 2'd1;

	typedef enum logic [1:0] {
		ACT_CONNECT  = 2'd0,
		ACT_CLOSE    = 2'd1,
		ACT_BAN      = 2'd2,
		ACT_DAY_TICK = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_BANNED     = 3'd1,
		STAT_DAY_LIMIT  = 3'd2,
		STAT_OPEN_LIMIT = 3'd3,
		STAT_FULL       = 3'd4,
		STAT_UNMATCHED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWEEP,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic             banned;
		logic [CNT_W-1:0] open_cnt;
	} stat_row_t;

endpackage

// ===== design/per_source_connection_admission.sv =====
// top level: per-source connection admission with a bounded source table
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  command   | start, busy                  | action, addr_high, addr_low
//  result    | done (one-cycle strobe)      | admitted, status
//  config    | cfg_valid, cfg_ready         | cfg_index, cfg_data
//
//  connect, close and ban walk the key ram over the fill sources held; a match ends the
//  walk early. one shared 128-bit key comparator walks the key ram one entry per cycle.
//  a day tick walks the same fill entries, one day-count write per cycle. busy is high
//  from the accepting edge until done.
//  reset leaves the table empty; no clearing pass, entries at or past fill are
//  unused. cfg_ready is always high; the result side cannot stall.
`include "per_source_connection_admission_assert.svh"

module per_source_connection_admission #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       action,
	input  logic [psca_pkg::KEY_W-1:0]       addr_high,
	input  logic [psca_pkg::KEY_W-1:0]       addr_low,
	output logic                             done,
	output logic                             admitted,
	output logic [2:0]                       status,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psca_pkg::CNT_W-1:0]       cfg_data
);

	import psca_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t state_q, state_d;

	action_t          act_q;
	logic [KEY_W-1:0] key_hi_q, key_lo_q;

	logic [CW-1:0] fill_q, idx_q;
	logic          rd_pend_q;
	logic [AW-1:0] rd_idx_q;

	logic             found_q;
	logic [AW-1:0]    slot_q;
	stat_row_t        stat_q;
	logic [CNT_W-1:0] day_q;

	logic [CNT_W-1:0] lim_day_q, lim_open_q;

	logic    done_q, admitted_q;
	status_t status_q;

	// ram ports
	logic               key_we, day_we, stat_we;
	logic [AW-1:0]      waddr, raddr;
	logic [2*KEY_W-1:0] key_rdata;
	logic [CNT_W-1:0]   day_wdata, day_rdata;
	stat_row_t          stat_wdata, stat_rdata;

	logic             hit, issued_all, full, claim;
	logic [CNT_W-1:0] cur_day;
	stat_row_t        cur_stat;
	logic             res_adm;
	status_t          res_st;

	psca_ram #(.WIDTH(2*KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(waddr),
		.wdata({key_hi_q, key_lo_q}),
		.raddr(raddr),
		.rdata(key_rdata)
	);

	psca_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_day_ram (
		.clk  (clk),
		.we   (day_we),
		.waddr(waddr),
		.wdata(day_wdata),
		.raddr(raddr),
		.rdata(day_rdata)
	);

	psca_ram #(.WIDTH($bits(stat_row_t)), .DEPTH(TABLE_ENTRIES)) u_stat_ram (
		.clk  (clk),
		.we   (stat_we),
		.waddr(waddr),
		.wdata(stat_wdata),
		.raddr(raddr),
		.rdata(stat_rdata)
	);

	// the shared comparator: one stored key against the request each cycle
	assign hit        = rd_pend_q && (key_rdata == {key_hi_q, key_lo_q});
	assign issued_all = (idx_q == fill_q);
	assign full       = (fill_q == CW'(TABLE_ENTRIES));
	assign raddr      = idx_q[AW-1:0];

	// a claimed slot starts from zero counts
	assign cur_day  = found_q ? day_q : '0;
	assign cur_stat = found_q ? stat_q : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (action_t'(action) == ACT_DAY_TICK) ? ST_SWEEP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || issued_all) begin
					state_d = ST_EXEC;
				end
			end
			ST_SWEEP: begin
				if (issued_all) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs: ram writes and the decision on the matched or claimed slot
	always_comb begin
		key_we     = 1'b0;
		day_we     = 1'b0;
		stat_we    = 1'b0;
		claim      = 1'b0;
		waddr      = found_q ? slot_q : fill_q[AW-1:0];
		day_wdata  = cur_day;
		stat_wdata = cur_stat;
		res_adm    = 1'b0;
		res_st     = STAT_OK;
		unique case (state_q)
			ST_SWEEP: begin
				waddr     = idx_q[AW-1:0];
				day_wdata = '0;
				day_we    = !issued_all;
			end
			ST_EXEC: begin
				case (act_q)
					ACT_CONNECT: begin
						if (found_q && cur_stat.banned) begin
							res_st = STAT_BANNED;
						end else if (lim_day_q == '0 && lim_open_q == '0) begin
							res_adm = 1'b1;
						end else if (!found_q && full) begin
							res_st = STAT_FULL;
						end else begin
							claim   = !found_q;
							day_we  = 1'b1;
							stat_we = 1'b1;
							if (lim_day_q != '0 && cur_day >= lim_day_q) begin
								stat_wdata.banned = 1'b1;
								res_st            = STAT_DAY_LIMIT;
							end else begin
								if (cur_day != CNT_MAX) begin
									day_wdata = cur_day + CNT_W'(1);
								end
								if (lim_open_q != '0 && cur_stat.open_cnt >= lim_open_q) begin
									res_st = STAT_OPEN_LIMIT;
								end else begin
									if (cur_stat.open_cnt != CNT_MAX) begin
										stat_wdata.open_cnt = cur_stat.open_cnt + CNT_W'(1);
									end
									res_adm = 1'b1;
								end
							end
						end
					end
					ACT_CLOSE: begin
						if (found_q) begin
							if (cur_stat.open_cnt != '0) begin
								stat_we             = 1'b1;
								stat_wdata.open_cnt = cur_stat.open_cnt - CNT_W'(1);
							end else begin
								res_st = STAT_UNMATCHED;
							end
						end
					end
					ACT_BAN: begin
						if (!found_q && full) begin
							res_st = STAT_FULL;
						end else begin
							claim             = !found_q;
							day_we            = 1'b1;
							stat_we           = 1'b1;
							stat_wdata.banned = 1'b1;
						end
					end
					default: begin
					end
				endcase
				key_we = claim;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			idx_q      <= '0;
			rd_pend_q  <= 1'b0;
			done_q     <= 1'b0;
			lim_day_q  <= '0;
			lim_open_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_DAY:  lim_day_q  <= cfg_data;
					CFG_MAX_OPEN: lim_open_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q     <= '0;
					rd_pend_q <= 1'b0;
				end
				ST_SCAN: begin
					if (!(hit || issued_all)) begin
						rd_pend_q <= 1'b1;
						idx_q     <= idx_q + CW'(1);
					end
				end
				ST_SWEEP: begin
					if (!issued_all) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_EXEC: begin
					if (claim) begin
						fill_q <= fill_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q    <= action_t'(action);
			key_hi_q <= addr_high;
			key_lo_q <= addr_low;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_q <= idx_q[AW-1:0];
			if (hit) begin
				found_q <= 1'b1;
				slot_q  <= rd_idx_q;
				stat_q  <= stat_rdata;
				day_q   <= day_rdata;
			end else if (issued_all) begin
				found_q <= 1'b0;
			end
		end
		if (state_q == ST_EXEC) begin
			admitted_q <= res_adm;
			status_q   <= res_st;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign admitted  = admitted_q;
	assign status    = status_q;
	assign cfg_ready = 1'b1;

	`PSCA_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_q <= CW'(TABLE_ENTRIES))
	`PSCA_ASSERT_IMPLY(a_scan_bound, state_q == ST_SCAN || state_q == ST_SWEEP, idx_q <= fill_q)
	`PSCA_ASSERT_NEXT(a_done_after_exec, state_q == ST_EXEC, done_q && state_q == ST_IDLE)
	`PSCA_ASSERT_IMPLY(a_admit_is_ok, done_q && admitted_q, status_q == STAT_OK)

endmodule

// ===== design/psca_ram.sv =====
// generic single-write, single-read ram with registered read data
module psca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
